>>> hw/rtl/xcs_pkg.sv
// types, character codes and byte judging functions for the xss character scrubber
// no dependencies; imported by xcs_front, xcs_back and xss_character_scrubber
`default_nettype none

package xcs_pkg;

	// characters the scrubber looks for, and the replacement character
	localparam logic [7:0] CH_PERCENT    = 8'h25;
	localparam logic [7:0] CH_DQUOTE     = 8'h22;
	localparam logic [7:0] CH_LT         = 8'h3C;
	localparam logic [7:0] CH_GT         = 8'h3E;
	localparam logic [7:0] CH_APOS       = 8'h27;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

	// hex digit ranges
	localparam logic [7:0] CH_DIG_0 = 8'h30;
	localparam logic [7:0] CH_DIG_9 = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_F  = 8'h46;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_F  = 8'h66;

	// one group of output words produced by one accepted input word
	typedef struct packed {
		logic [2:0][7:0] bytes;    // already scrubbed
		logic [2:0]      danger;   // word was replaced, count it
		logic [1:0]      last_idx; // index of the final word in the group
		logic            last;     // group closes the string
	} grp_t;

	// dangerous character test
	function automatic logic is_bad(input logic [7:0] v);
		return (v == CH_DQUOTE) || (v == CH_LT) || (v == CH_GT) || (v == CH_APOS);
	endfunction

	// hex digit decode: {valid, nibble}
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd0;
		if (c >= CH_DIG_0 && c <= CH_DIG_9) begin
			d = c - CH_DIG_0;
			return {1'b1, d[3:0]};
		end else if (c >= CH_UP_A && c <= CH_UP_F) begin
			d = c - CH_UP_A + 8'd10;
			return {1'b1, d[3:0]};
		end else if (c >= CH_LO_A && c <= CH_LO_F) begin
			d = c - CH_LO_A + 8'd10;
			return {1'b1, d[3:0]};
		end
		return 5'd0;
	endfunction

	// judge a byte with two lookahead bytes, decoding a percent escape
	function automatic logic judge_esc(input logic [7:0] b, input logic [7:0] la0,
			input logic [7:0] la1);
		logic [4:0] hi;
		logic [4:0] lo;
		hi = hex_val(la0);
		lo = hex_val(la1);
		if (b == CH_PERCENT && hi[4] && lo[4])
			return is_bad({hi[3:0], lo[3:0]});
		return is_bad(b);
	endfunction

	// replacement of a dangerous byte
	function automatic logic [7:0] scrub(input logic [7:0] b, input logic bad);
		return bad ? CH_UNDERSCORE : b;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/xcs_front.sv
// front end of the scrubber: lookahead window and judging of each byte
// depends on xcs_pkg; feeds word groups into xcs_fifo
`default_nettype none

module xcs_front (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              s_tvalid,
	output logic             s_tready,
	input  wire  [7:0]       s_tdata,   // [7:0] in_byte
	input  wire              s_tlast,
	output logic             grp_valid,
	output xcs_pkg::grp_t    grp,
	input  wire              grp_ready
);
	import xcs_pkg::*;

	logic [7:0] win0_q;
	logic [7:0] win1_q;
	logic [1:0] fill_q;
	logic       accept;
	logic [2:0] bad;

	assign s_tready  = grp_ready;
	assign accept    = s_tvalid && s_tready;
	assign grp_valid = s_tvalid && (s_tlast || fill_q == 2'd2);

	// build the group of judged words for this input word
	always_comb begin
		bad          = 3'b000;
		grp.bytes    = '{default: 8'd0};
		grp.last_idx = 2'd0;
		grp.last     = s_tlast;
		if (!s_tlast) begin
			grp.bytes[0] = win0_q;
			bad[0]       = judge_esc(win0_q, win1_q, s_tdata);
		end else begin
			unique case (fill_q)
				2'd1: begin
					grp.bytes[0] = win0_q;
					grp.bytes[1] = s_tdata;
					bad[0]       = is_bad(win0_q);
					bad[1]       = is_bad(s_tdata);
					grp.last_idx = 2'd1;
				end
				2'd2: begin
					grp.bytes[0] = win0_q;
					grp.bytes[1] = win1_q;
					grp.bytes[2] = s_tdata;
					bad[0]       = judge_esc(win0_q, win1_q, s_tdata);
					bad[1]       = is_bad(win1_q);
					bad[2]       = is_bad(s_tdata);
					grp.last_idx = 2'd2;
				end
				default: begin
					grp.bytes[0] = s_tdata;
					bad[0]       = is_bad(s_tdata);
				end
			endcase
		end
		grp.danger   = bad;
		grp.bytes[0] = scrub(grp.bytes[0], bad[0]);
		grp.bytes[1] = scrub(grp.bytes[1], bad[1]);
		grp.bytes[2] = scrub(grp.bytes[2], bad[2]);
	end

	// window shift register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win0_q <= 8'd0;
			win1_q <= 8'd0;
			fill_q <= 2'd0;
		end else if (accept) begin
			if (s_tlast) begin
				win0_q <= 8'd0;
				win1_q <= 8'd0;
				fill_q <= 2'd0;
			end else if (fill_q == 2'd0) begin
				win0_q <= s_tdata;
				fill_q <= 2'd1;
			end else if (fill_q == 2'd1) begin
				win1_q <= s_tdata;
				fill_q <= 2'd2;
			end else begin
				win0_q <= win1_q;
				win1_q <= s_tdata;
			end
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/xcs_fifo.sv
// small register queue between the front and back of the scrubber
// no dependencies; generic width and power-of-two depth
`default_nettype none

module xcs_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              wr_valid,
	output logic             wr_ready,
	input  wire  [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  wire              rd_pop,
	output logic [WIDTH-1:0] rd_data
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      count_q;
	logic             push;
	logic             pop;

	assign wr_ready = count_q != (AW+1)'(DEPTH);
	assign rd_valid = count_q != '0;
	assign rd_data  = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_pop && rd_valid;

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/xcs_back.sv
// back end of the scrubber: expands word groups, keeps the replacement count
// depends on xcs_pkg; takes groups from xcs_fifo, drives the output stream
`default_nettype none

module xcs_back #(
	parameter int COUNT_BITS = 16
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              grp_valid,
	input  xcs_pkg::grp_t    grp,
	output logic             grp_pop,
	output logic             m_tvalid,
	input  wire              m_tready,
	output logic [31:0]      m_tdata,   // [7:0] out_byte, [23:8] replaced_count,
	                                    // [24] attack_found, [31:25] zero
	output logic             m_tlast
);
	import xcs_pkg::*;

	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	logic [1:0]            k_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic                  m_valid_q;
	logic [7:0]            byte_q;
	logic [15:0]           shown_q;
	logic                  attack_q;
	logic                  last_q;

	logic                  fire;
	logic                  at_end;
	logic                  close;
	logic [7:0]            sel_byte;
	logic                  sel_bad;
	logic [COUNT_BITS-1:0] cnt_inc;
	logic [15:0]           shown;

	// select the current word of the head group
	assign sel_byte = grp.bytes[k_q];
	assign sel_bad  = grp.danger[k_q];
	assign at_end   = k_q == grp.last_idx;
	assign close    = at_end && grp.last;
	assign fire     = grp_valid && (!m_valid_q || m_tready);
	assign grp_pop  = fire && at_end;

	// saturating count including this word
	assign cnt_inc = (sel_bad && cnt_q != CNT_MAX) ? cnt_q + 1'b1 : cnt_q;

	// clamp to the 16-bit field
	generate
		if (COUNT_BITS > 16) begin : g_clamp
			assign shown = (|cnt_inc[COUNT_BITS-1:16]) ? 16'hFFFF : cnt_inc[15:0];
		end else begin : g_extend
			assign shown = 16'(cnt_inc);
		end
	endgenerate

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q       <= 2'd0;
			cnt_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				k_q       <= at_end ? 2'd0 : k_q + 2'd1;
				cnt_q     <= close ? '0 : cnt_inc;
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (fire) begin
			byte_q   <= sel_byte;
			shown_q  <= shown;
			attack_q <= cnt_inc != '0;
			last_q   <= close;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'd0, attack_q, shown_q, byte_q};
	assign m_tlast  = last_q;

`ifndef SYNTHESIS
	a_idle_index: assert property (@(posedge clk) disable iff (!arst_n)
		!grp_valid |-> k_q == 2'd0)
		else $error("word index moved without a group");
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		grp_valid |-> k_q <= grp.last_idx)
		else $error("word index beyond the group");
	a_count_clear: assert property (@(posedge clk) disable iff (!arst_n)
		fire && close |=> cnt_q == '0)
		else $error("count not cleared after the final word");
	a_attack_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> attack_q == (shown_q != 16'd0))
		else $error("attack flag disagrees with count");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/xss_character_scrubber.sv
// A byte's output word enters the group queue with the input word that completes
//   its two-byte lookahead (or with the final byte), and leaves through the output register.
// Throughput: one input word per cycle while the queue has room; a final byte releases one
//   to three output words from the back end's group expansion, one per cycle when not stalled.
// Reset (arst_n low, asynchronous): window, fill, queue, count and output valid clear.
// Top level of the scrubber; depends on xcs_pkg, xcs_front, xcs_fifo and xcs_back
`default_nettype none

module xss_character_scrubber #(
	parameter int COUNT_BITS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] in_byte
	input  wire         s_tlast,
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata,   // [7:0] out_byte, [23:8] replaced_count,
	                               // [24] attack_found, [31:25] zero
	output logic        m_tlast
);
	import xcs_pkg::*;

	localparam int GW = $bits(grp_t);

	logic   push_valid;
	logic   push_ready;
	grp_t   push_grp;
	logic   head_valid;
	logic   head_pop;
	grp_t   head_grp;
	logic [GW-1:0] head_bits;

	// window and judging
	xcs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.grp_valid (push_valid),
		.grp       (push_grp),
		.grp_ready (push_ready)
	);

	// group queue
	xcs_fifo #(
		.WIDTH (GW),
		.DEPTH (4)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push_valid),
		.wr_ready (push_ready),
		.wr_data  (push_grp),
		.rd_valid (head_valid),
		.rd_pop   (head_pop),
		.rd_data  (head_bits)
	);

	assign head_grp = grp_t'(head_bits);

	// expansion, counting and output register
	xcs_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.grp_valid (head_valid),
		.grp       (head_grp),
		.grp_pop   (head_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

`default_nettype wire

>>> sim/xss_character_scrubber_tb.sv
// self-checking bench for xss_character_scrubber: streams query strings, predicts every output word
// depends on xcs_pkg (character codes) and the xss_character_scrubber rtl
`default_nettype none

module xss_character_scrubber_tb;
	import xcs_pkg::*;

	localparam int CNT_BITS = 16;

	// one expected output word
	typedef struct {
		logic [7:0]  out_byte;
		logic        out_last;
		logic [15:0] replaced_count;
		logic        attack_found;
	} scrub_word_t;

	// scrubber prediction plus the queue of words still to come out
	class scrub_predictor;
		logic [7:0]        held [2];
		int                fill = 0;
		longint unsigned   count = 0;
		longint unsigned   count_max = (64'd1 << CNT_BITS) - 1;
		scrub_word_t       expected_words [$];
		int                mismatches = 0;

		function int hex_nibble(logic [7:0] c);
			if (c >= CH_DIG_0 && c <= CH_DIG_9) return int'(c - CH_DIG_0);
			if (c >= CH_UP_A && c <= CH_UP_F) return int'(c - CH_UP_A) + 10;
			if (c >= CH_LO_A && c <= CH_LO_F) return int'(c - CH_LO_A) + 10;
			return -1;
		endfunction

		// judge one byte against whatever lookahead exists and queue its word
		function void scrub_byte(logic [7:0] b, int avail, logic [7:0] la0, logic [7:0] la1,
				logic last);
			scrub_word_t w;
			int hi;
			int lo;
			logic [7:0] v;
			v = b;
			if (b == CH_PERCENT && avail >= 2) begin
				hi = hex_nibble(la0);
				lo = hex_nibble(la1);
				if (hi >= 0 && lo >= 0) v = 8'(hi * 16 + lo);
			end
			w.out_byte = b;
			if (v == CH_DQUOTE || v == CH_LT || v == CH_GT || v == CH_APOS) begin
				w.out_byte = CH_UNDERSCORE;
				if (count < count_max) count++;
			end
			w.out_last = last;
			w.replaced_count = (count > 64'hFFFF) ? 16'hFFFF : 16'(count);
			w.attack_found = (count != 0);
			expected_words.push_back(w);
		endfunction

		// accepted input word
		function void take_byte(logic [7:0] b, logic last);
			logic [7:0] seq [3];
			int n;
			int avail;
			if (!last) begin
				if (fill < 2) begin
					held[fill] = b;
					fill++;
					return;
				end
				scrub_byte(held[0], 2, held[1], b, 1'b0);
				held[0] = held[1];
				held[1] = b;
				return;
			end
			// final byte flushes the window, lookahead stops at the end of the string
			n = fill;
			for (int i = 0; i < n; i++) seq[i] = held[i];
			seq[n] = b;
			n++;
			for (int i = 0; i < n; i++) begin
				avail = n - 1 - i;
				scrub_byte(seq[i], avail, (i + 1 < 3) ? seq[i + 1] : 8'h00,
					(i + 2 < 3) ? seq[i + 2] : 8'h00, i == n - 1);
			end
			held[0] = 8'h00;
			held[1] = 8'h00;
			fill = 0;
			count = 0;
		endfunction

		// accepted output word against the oldest expectation
		function void check_word(logic [31:0] data, logic last);
			scrub_word_t w;
			if (expected_words.size() == 0) begin
				$error("unexpected output word: tdata %h tlast %b", data, last);
				mismatches++;
				return;
			end
			w = expected_words.pop_front();
			if (data[7:0] !== w.out_byte) begin
				$error("out_byte: expected %h, got %h", w.out_byte, data[7:0]);
				mismatches++;
			end
			if (last !== w.out_last) begin
				$error("out_last: expected %b, got %b", w.out_last, last);
				mismatches++;
			end
			if (data[23:8] !== w.replaced_count) begin
				$error("replaced_count: expected %0d, got %0d", w.replaced_count, data[23:8]);
				mismatches++;
			end
			if (data[24] !== w.attack_found) begin
				$error("attack_found: expected %b, got %b", w.attack_found, data[24]);
				mismatches++;
			end
			if (data[31:25] !== 7'd0) begin
				$error("tdata padding: expected %h, got %h", 7'd0, data[31:25]);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tlast;

	int gap_pct   = 0;
	int stall_pct = 0;

	scrub_predictor pred = new;

	xss_character_scrubber #(
		.COUNT_BITS(CNT_BITS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// receiver back-pressure
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// output word monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			pred.check_word(m_tdata, m_tlast);
	end

	function automatic logic [7:0] hex_char(logic [3:0] n);
		if (n < 4'd10) return CH_DIG_0 + 8'(n);
		if ($urandom_range(1)) return CH_UP_A + 8'(n) - 8'd10;
		return CH_LO_A + 8'(n) - 8'd10;
	endfunction

	// one input word, with random idle cycles ahead of it
	task automatic send_word(input logic [7:0] b, input logic last);
		bit done;
		done = 0;
		while (!done) begin
			@(negedge clk);
			if ($urandom_range(99) < gap_pct) begin
				s_tvalid <= 1'b0;
			end else begin
				s_tvalid <= 1'b1;
				s_tdata  <= b;
				s_tlast  <= last;
				do @(posedge clk); while (!s_tready);
				pred.take_byte(b, last);
				done = 1;
			end
		end
	endtask

	task automatic send_string(input logic [7:0] s [$]);
		foreach (s[i]) send_word(s[i], i == s.size() - 1);
	endtask

	initial begin
		logic [7:0] str [$];
		logic [7:0] danger_set [4];
		logic [7:0] code;
		int gap_tab [4];
		int stall_tab [4];
		int sent;
		int len;
		int r;
		danger_set = '{CH_DQUOTE, CH_APOS, CH_LT, CH_GT};
		gap_tab    = '{0, 66, 0, 32};
		stall_tab  = '{0, 0, 66, 32};

		repeat (5) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// directed strings
		// zero and all-ones bytes, lowercase escape of '<', raw double quote
		str = {8'h00, 8'hFF, CH_PERCENT, 8'h33, 8'h63, CH_DQUOTE};
		send_string(str);
		// escape of an apostrophe closing the string
		str = {CH_PERCENT, 8'h32, 8'h37};
		send_string(str);
		// one-byte string
		str = {CH_GT};
		send_string(str);
		// decoded high byte is harmless, raw apostrophe
		str = {CH_PERCENT, 8'h46, 8'h46, CH_APOS};
		send_string(str);
		// percent with a single byte left before the end
		str = {8'h61, CH_PERCENT, 8'h33};
		send_string(str);
		// non-hex escape, then uppercase escape of '>'
		str = {CH_PERCENT, 8'h47, 8'h31, CH_PERCENT, 8'h33, 8'h45};
		send_string(str);
		// percent as the final byte
		str = {CH_LT, CH_PERCENT};
		send_string(str);

		// run of '<' to build up the count
		for (int i = 0; i < 20; i++) send_word(CH_LT, i == 19);

		// random strings over the idling phases
		for (int ph = 0; ph < 4; ph++) begin
			gap_pct   = gap_tab[ph];
			stall_pct = stall_tab[ph];
			sent = 0;
			while (sent < 50) begin
				str.delete();
				len = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 14);
				while (str.size() < len) begin
					r = $urandom_range(99);
					if (r < 30) begin
						str.push_back(8'($urandom_range(255)));
					end else if (r < 50) begin
						str.push_back(danger_set[$urandom_range(3)]);
					end else if (r < 85) begin
						// well-formed escape, mostly of a dangerous character
						code = (r < 68) ? danger_set[$urandom_range(3)] : 8'($urandom_range(255));
						str.push_back(CH_PERCENT);
						str.push_back(hex_char(code[7:4]));
						str.push_back(hex_char(code[3:0]));
					end else begin
						// broken escape
						str.push_back(CH_PERCENT);
						str.push_back(8'($urandom_range(255)));
					end
				end
				send_string(str);
				sent += str.size();
			end
		end
		@(negedge clk) s_tvalid <= 1'b0;

		// drain, then watch for anything stray
		while (pred.expected_words.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (pred.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// watchdog
	initial begin
		#5000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire

>>> files.f
hw/rtl/xcs_pkg.sv
hw/rtl/xcs_front.sv
hw/rtl/xcs_fifo.sv
hw/rtl/xcs_back.sv
hw/rtl/xss_character_scrubber.sv
sim/xss_character_scrubber_tb.sv
